// ===== design/ccbe_pkg.sv =====
package ccbe_pkg;

    // CORDIC vectoring steps per arccosine
    localparam int CORDIC_STEPS = 24;
    localparam int CIT_W        = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // angle constants, Q32 radians
    localparam logic [35:0] PI_Q32      = 36'd13493037705;
    localparam logic [35:0] HALF_PI_Q32 = 36'd6746518852;

    localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
    localparam logic [63:0] ONE_Q60        = 64'h1000_0000_0000_0000;
    localparam logic [47:0] ENERGY_MAX     = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] RIGIDITY_RESET = 32'd65536;

    // multiplier operand selection
    typedef enum logic [2:0] {
        MS_SQ,
        MS_DOT,
        MS_MAG,
        MS_AM,
        MS_ELO,
        MS_EHI
    } t_msel;

    // where the registered product goes
    typedef enum logic [1:0] {
        MD_ACC_SET,
        MD_ACC_ADD,
        MD_AUX_SET
    } t_mdest;

    typedef struct packed {
        logic   capture;
        logic   first_store;
        logic   load_edge;
        logic   closing;
        logic   norm_step;
        logic   unit_zero;
        logic   unit_write;
        logic   mul_go;
        t_msel  mul_sel;
        t_mdest mul_dest;
        logic [1:0] lane;
        logic   pair;
        logic   sqrt_start;
        logic   sqrt_src;
        logic   sqrt_step;
        logic   div_start;
        logic   div_step;
        logic   clamp;
        logic   cord_init;
        logic   cord_step;
        logic   sum_add;
        logic   commit;
        logic   emit;
        logic   emit_short;
    } t_cmd;

    typedef struct packed {
        logic [1:0] seen;
        logic       last;
        logic       edge_zero;
        logic       norm_ok;
        logic       sqrt_last;
        logic       div_last;
        logic       cord_last;
    } t_stat;

    // arctan(2^-i) in Q32 radians
    function automatic logic [31:0] atan_q32(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd3373259426;
            5'd1:  v = 32'd1991351318;
            5'd2:  v = 32'd1052175346;
            5'd3:  v = 32'd534100635;
            5'd4:  v = 32'd268086748;
            5'd5:  v = 32'd134174063;
            5'd6:  v = 32'd67103403;
            5'd7:  v = 32'd33553749;
            5'd8:  v = 32'd16777131;
            5'd9:  v = 32'd8388597;
            5'd10: v = 32'd4194303;
            5'd11: v = 32'd2097152;
            5'd12: v = 32'd1048576;
            5'd13: v = 32'd524288;
            5'd14: v = 32'd262144;
            5'd15: v = 32'd131072;
            5'd16: v = 32'd65536;
            5'd17: v = 32'd32768;
            5'd18: v = 32'd16384;
            5'd19: v = 32'd8192;
            5'd20: v = 32'd4096;
            5'd21: v = 32'd2048;
            5'd22: v = 32'd1024;
            5'd23: v = 32'd512;
            5'd24: v = 32'd256;
            5'd25: v = 32'd128;
            5'd26: v = 32'd64;
            5'd27: v = 32'd32;
            5'd28: v = 32'd16;
            5'd29: v = 32'd8;
            5'd30: v = 32'd4;
            default: v = 32'd2;
        endcase
        return v;
    endfunction

endpackage

// ===== design/ccbe_dp.sv =====
module ccbe_dp import ccbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic               i_last_vertex,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    output t_stat              o_stat,
    output logic [47:0]        o_energy,
    output logic               o_degenerate
);

    // control state
    logic [31:0] r_rigidity;
    logic [63:0] r_sum;
    logic [1:0]  r_seen;
    logic        r_deg;
    logic        r_pvalid;

    // payload state
    logic [31:0] r_v [3];
    logic        r_last;
    logic [31:0] r_first [3];
    logic [31:0] r_prev [3];
    logic [31:0] r_first_e [3];
    logic [31:0] r_prev_e [3];
    logic [31:0] r_e [3];
    logic [32:0] r_m [3];
    logic [32:0] r_mx;
    logic        r_neg [3];
    logic [63:0] r_prod;
    t_mdest      r_pdest;
    logic [63:0] r_acc;
    logic [63:0] r_aux;
    logic [63:0] r_sx;
    logic [35:0] r_srem;
    logic [31:0] r_root;
    logic [4:0]  r_scnt;
    logic [31:0] r_drem [3];
    logic [30:0] r_dnum [3];
    logic [30:0] r_q [3];
    logic [4:0]  r_dcnt;
    logic [31:0] r_c;
    logic [30:0] r_mag;
    logic signed [35:0] r_cx;
    logic signed [35:0] r_cy;
    logic signed [35:0] r_cz;
    logic [CIT_W-1:0]   r_it;
    logic [47:0] r_energy;
    logic        r_odeg;

    logic [32:0] w_d [3];
    logic [32:0] w_abs [3];
    logic [32:0] w_mx;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic signed [65:0] w_prod;
    logic [35:0] w_zc;
    logic [35:0] w_zr;
    logic [29:0] w_am;
    logic [35:0] w_srs;
    logic [35:0] w_strial;
    logic [61:0] w_num [3];
    logic [32:0] w_drs [3];
    logic        w_dge [3];
    logic [30:0] w_qc [3];
    logic [31:0] w_u [3];
    logic [63:0] w_mag64;
    logic [63:0] w_mr;
    logic [33:0] w_mr30;
    logic [30:0] w_mcap;
    logic signed [35:0] w_xs;
    logic signed [35:0] w_ys;
    logic signed [35:0] w_atan;
    logic [63:0] w_sqr;
    logic [64:0] w_sum65;
    logic [48:0] w_e49;
    logic [47:0] w_energy;

    // edge difference, magnitudes and largest magnitude
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.closing) begin
                w_d[k] = {r_first[k][31], r_first[k]} - {r_v[k][31], r_v[k]};
            end else begin
                w_d[k] = {r_v[k][31], r_v[k]} - {r_prev[k][31], r_prev[k]};
            end
            w_abs[k] = w_d[k][32] ? (33'd0 - w_d[k]) : w_d[k];
        end
        w_mx = w_abs[0];
        if (w_abs[1] > w_mx) begin
            w_mx = w_abs[1];
        end
        if (w_abs[2] > w_mx) begin
            w_mx = w_abs[2];
        end
    end

    // clamp angle to [0, pi] and round to Q28
    always_comb begin
        if (r_cz[35]) begin
            w_zc = '0;
        end else if (36'(r_cz) > PI_Q32) begin
            w_zc = PI_Q32;
        end else begin
            w_zc = 36'(r_cz);
        end
        w_zr = w_zc + 36'd8;
        w_am = w_zr[33:4];
    end

    // shared multiplier operands
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.mul_sel)
            MS_SQ: begin
                w_ma = {2'b00, r_m[i_cmd.lane][30:0]};
                w_mb = {2'b00, r_m[i_cmd.lane][30:0]};
            end
            MS_DOT: begin
                if (i_cmd.pair) begin
                    w_ma = {r_first_e[i_cmd.lane][31], r_first_e[i_cmd.lane]};
                end else begin
                    w_ma = {r_prev_e[i_cmd.lane][31], r_prev_e[i_cmd.lane]};
                end
                w_mb = {r_e[i_cmd.lane][31], r_e[i_cmd.lane]};
            end
            MS_MAG: begin
                w_ma = {2'b00, r_mag};
                w_mb = {2'b00, r_mag};
            end
            MS_AM: begin
                w_ma = {3'b000, w_am};
                w_mb = {3'b000, w_am};
            end
            MS_ELO: begin
                w_ma = {1'b0, r_sum[31:0]};
                w_mb = {1'b0, r_rigidity};
            end
            MS_EHI: begin
                w_ma = {1'b0, r_sum[63:32]};
                w_mb = {1'b0, r_rigidity};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    // square root step, divider lanes and unit components
    always_comb begin
        w_srs    = {r_srem[33:0], r_sx[63:62]};
        w_strial = {2'b00, r_root, 2'b01};
        for (int k = 0; k < 3; k++) begin
            w_num[k] = {1'b0, r_m[k][30:0], 30'd0} + {31'd0, r_root[31:1]};
            w_drs[k] = {r_drem[k], r_dnum[k][30]};
            w_dge[k] = w_drs[k] >= {1'b0, r_root};
            w_qc[k]  = (r_q[k] > ONE_Q30[30:0]) ? ONE_Q30[30:0] : r_q[k];
            w_u[k]   = r_neg[k] ? (32'd0 - {1'b0, w_qc[k]}) : {1'b0, w_qc[k]};
        end
    end

    // dot product magnitude, rounded and clamped to one
    always_comb begin
        w_mag64 = r_acc[63] ? (64'd0 - r_acc) : r_acc;
        w_mr    = w_mag64 + 64'h2000_0000;
        w_mr30  = w_mr[63:30];
        w_mcap  = (w_mr30 > {2'b00, ONE_Q30}) ? ONE_Q30[30:0] : w_mr30[30:0];
    end

    // CORDIC step, angle sum and energy
    always_comb begin
        w_xs    = r_cx >>> r_it;
        w_ys    = r_cy >>> r_it;
        w_atan  = {4'b0000, atan_q32(5'(r_it))};
        w_sqr   = r_acc + 64'h8000_0000;
        w_sum65 = {1'b0, r_sum} + {33'd0, w_sqr[63:32]};
        w_e49   = {1'b0, r_acc[32:0], 15'd0} + {2'b00, r_aux[63:17]};
        if ((|r_acc[63:33]) || w_e49[48]) begin
            w_energy = ENERGY_MAX;
        end else begin
            w_energy = w_e49[47:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rigidity <= RIGIDITY_RESET;
            r_sum      <= '0;
            r_seen     <= '0;
            r_deg      <= 1'b0;
            r_pvalid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_rigidity <= i_cfg_wr_data;
            end
            r_pvalid <= i_cmd.mul_go;
            if (i_cmd.first_store || i_cmd.commit) begin
                r_seen <= (r_seen == 2'd3) ? 2'd3 : r_seen + 2'd1;
            end
            if (i_cmd.unit_zero) begin
                r_deg <= 1'b1;
            end
            if (i_cmd.sum_add) begin
                r_sum <= w_sum65[64] ? '1 : w_sum65[63:0];
            end
            if (i_cmd.emit) begin
                r_sum  <= '0;
                r_seen <= '0;
                r_deg  <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        // capture the vertex
        if (i_cmd.capture) begin
            r_v[0] <= i_coord_x;
            r_v[1] <= i_coord_y;
            r_v[2] <= i_coord_z;
            r_last <= i_last_vertex;
        end
        if (i_cmd.first_store) begin
            for (int k = 0; k < 3; k++) begin
                r_first[k] <= r_v[k];
                r_prev[k]  <= r_v[k];
            end
        end
        // load edge magnitudes
        if (i_cmd.load_edge) begin
            for (int k = 0; k < 3; k++) begin
                r_m[k]   <= w_abs[k];
                r_neg[k] <= w_d[k][32];
            end
            r_mx <= w_mx;
        end
        // bring largest magnitude into [2^30, 2^31)
        if (i_cmd.norm_step) begin
            if (r_mx[32:31] != 2'b00) begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k] <= r_m[k] >> 1;
                end
                r_mx <= r_mx >> 1;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_m[k] <= r_m[k] << 1;
                end
                r_mx <= r_mx << 1;
            end
        end
        // multiplier result and its consumer
        if (i_cmd.mul_go) begin
            r_prod  <= w_prod[63:0];
            r_pdest <= i_cmd.mul_dest;
        end
        if (r_pvalid) begin
            case (r_pdest)
                MD_ACC_SET: r_acc <= r_prod;
                MD_ACC_ADD: r_acc <= r_acc + r_prod;
                MD_AUX_SET: r_aux <= r_prod;
                default:    r_aux <= r_prod;
            endcase
        end
        // square root, two bits a step
        if (i_cmd.sqrt_start) begin
            r_sx   <= i_cmd.sqrt_src ? (ONE_Q60 - r_acc) : r_acc;
            r_srem <= '0;
            r_root <= '0;
            r_scnt <= '0;
        end else if (i_cmd.sqrt_step) begin
            if (w_srs >= w_strial) begin
                r_srem <= w_srs - w_strial;
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_srem <= w_srs;
                r_root <= {r_root[30:0], 1'b0};
            end
            r_sx   <= r_sx << 2;
            r_scnt <= r_scnt + 5'd1;
        end
        // three divider lanes, one quotient bit a step
        if (i_cmd.div_start) begin
            for (int k = 0; k < 3; k++) begin
                r_drem[k] <= {1'b0, w_num[k][61:31]};
                r_dnum[k] <= w_num[k][30:0];
                r_q[k]    <= '0;
            end
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            for (int k = 0; k < 3; k++) begin
                if (w_dge[k]) begin
                    r_drem[k] <= 32'(w_drs[k] - {1'b0, r_root});
                    r_q[k]    <= {r_q[k][29:0], 1'b1};
                end else begin
                    r_drem[k] <= w_drs[k][31:0];
                    r_q[k]    <= {r_q[k][29:0], 1'b0};
                end
                r_dnum[k] <= r_dnum[k] << 1;
            end
            r_dcnt <= r_dcnt + 5'd1;
        end
        // unit vector of the edge
        if (i_cmd.unit_write) begin
            for (int k = 0; k < 3; k++) begin
                r_e[k] <= w_u[k];
            end
        end
        if (i_cmd.unit_zero) begin
            for (int k = 0; k < 3; k++) begin
                r_e[k] <= '0;
            end
        end
        // cosine from the dot product
        if (i_cmd.clamp) begin
            r_mag <= w_mcap;
            r_c   <= r_acc[63] ? (32'd0 - {1'b0, w_mcap}) : {1'b0, w_mcap};
        end
        // CORDIC vectoring
        if (i_cmd.cord_init) begin
            if (r_c[31]) begin
                r_cx <= {4'b0000, r_root};
                r_cy <= 36'sd0 - {{4{r_c[31]}}, r_c};
                r_cz <= HALF_PI_Q32;
            end else begin
                r_cx <= {{4{r_c[31]}}, r_c};
                r_cy <= {4'b0000, r_root};
                r_cz <= '0;
            end
            r_it <= '0;
        end else if (i_cmd.cord_step) begin
            if (!r_cy[35]) begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_cz <= r_cz + w_atan;
            end else begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_cz <= r_cz - w_atan;
            end
            r_it <= r_it + CIT_W'(1);
        end
        // advance the chain
        if (i_cmd.commit) begin
            for (int k = 0; k < 3; k++) begin
                r_prev_e[k] <= r_e[k];
                r_prev[k]   <= r_v[k];
                if (r_seen == 2'd1) begin
                    r_first_e[k] <= r_e[k];
                end
            end
        end
        // result register
        if (i_cmd.emit) begin
            if (i_cmd.emit_short) begin
                r_energy <= '0;
                r_odeg   <= 1'b1;
            end else begin
                r_energy <= w_energy;
                r_odeg   <= r_deg;
            end
        end
    end

    assign o_stat.seen      = r_seen;
    assign o_stat.last      = r_last;
    assign o_stat.edge_zero = (r_mx == '0);
    assign o_stat.norm_ok   = (r_mx[32:31] == 2'b00) && r_mx[30];
    assign o_stat.sqrt_last = (r_scnt == 5'd31);
    assign o_stat.div_last  = (r_dcnt == 5'd30);
    assign o_stat.cord_last = (r_it == CIT_W'(CORDIC_STEPS - 1));

    assign o_energy     = r_energy;
    assign o_degenerate = r_odeg;

endmodule

// ===== design/ccbe_ctrl.sv =====
module ccbe_ctrl import ccbe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid
);

    typedef enum logic [29:0] {
        S_IDLE    = 30'h0000_0001,
        S_FIRST   = 30'h0000_0002,
        S_DIFF    = 30'h0000_0004,
        S_NORM    = 30'h0000_0008,
        S_UNITZ   = 30'h0000_0010,
        S_SQ      = 30'h0000_0020,
        S_SQW     = 30'h0000_0040,
        S_RSQRT   = 30'h0000_0080,
        S_RSQRTW  = 30'h0000_0100,
        S_DIV     = 30'h0000_0200,
        S_DIVW    = 30'h0000_0400,
        S_UNIT    = 30'h0000_0800,
        S_DOT     = 30'h0000_1000,
        S_DOTW    = 30'h0000_2000,
        S_CLAMP   = 30'h0000_4000,
        S_MSQ     = 30'h0000_8000,
        S_MSQW    = 30'h0001_0000,
        S_YSQRT   = 30'h0002_0000,
        S_YSQRTW  = 30'h0004_0000,
        S_CINIT   = 30'h0008_0000,
        S_CORD    = 30'h0010_0000,
        S_AMSQ    = 30'h0020_0000,
        S_AMW     = 30'h0040_0000,
        S_SUM     = 30'h0080_0000,
        S_COMMIT  = 30'h0100_0000,
        S_LAST    = 30'h0200_0000,
        S_ENLO    = 30'h0400_0000,
        S_ENHI    = 30'h0800_0000,
        S_ENW     = 30'h1000_0000,
        S_EMIT    = 30'h2000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_pair, n_pair;
    logic       r_closing, n_closing;
    logic       r_short, n_short;
    logic       r_out_valid, n_out_valid;
    t_cmd       w_cmd;
    t_state     w_post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_pair      <= 1'b0;
            r_closing   <= 1'b0;
            r_short     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_pair      <= n_pair;
            r_closing   <= n_closing;
            r_short     <= n_short;
            r_out_valid <= n_out_valid;
        end
    end

    // after a unit vector: angle with the previous edge, or just advance
    assign w_post = (r_closing || (i_stat.seen != 2'd1)) ? S_DOT : S_COMMIT;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_pair      = r_pair;
        n_closing   = r_closing;
        n_short     = r_short;
        n_out_valid = r_out_valid & ~i_out_ready;
        w_cmd            = '0;
        w_cmd.closing    = r_closing;
        w_cmd.lane       = r_k;
        w_cmd.pair       = r_pair;
        w_cmd.emit_short = r_short;
        w_cmd.mul_sel    = MS_SQ;
        w_cmd.mul_dest   = MD_ACC_SET;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_closing     = 1'b0;
                    n_state       = (i_stat.seen == 2'd0) ? S_FIRST : S_DIFF;
                end
            end
            S_FIRST: begin
                w_cmd.first_store = 1'b1;
                n_state           = S_LAST;
            end
            S_DIFF: begin
                w_cmd.load_edge = 1'b1;
                n_state         = S_NORM;
            end
            S_NORM: begin
                if (i_stat.edge_zero) begin
                    n_state = S_UNITZ;
                end else if (i_stat.norm_ok) begin
                    n_k     = '0;
                    n_state = S_SQ;
                end else begin
                    w_cmd.norm_step = 1'b1;
                end
            end
            S_UNITZ: begin
                w_cmd.unit_zero = 1'b1;
                n_k             = '0;
                n_pair          = 1'b0;
                n_state         = w_post;
            end
            // squared length, one component a cycle
            S_SQ: begin
                w_cmd.mul_go   = 1'b1;
                w_cmd.mul_sel  = MS_SQ;
                w_cmd.mul_dest = (r_k == 2'd0) ? MD_ACC_SET : MD_ACC_ADD;
                if (r_k == 2'd2) begin
                    n_state = S_SQW;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_SQW: begin
                n_state = S_RSQRT;
            end
            S_RSQRT: begin
                w_cmd.sqrt_start = 1'b1;
                n_state          = S_RSQRTW;
            end
            S_RSQRTW: begin
                w_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_last) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIVW;
            end
            S_DIVW: begin
                w_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_UNIT;
                end
            end
            S_UNIT: begin
                w_cmd.unit_write = 1'b1;
                n_k              = '0;
                n_pair           = 1'b0;
                n_state          = w_post;
            end
            // dot product, one component a cycle
            S_DOT: begin
                w_cmd.mul_go   = 1'b1;
                w_cmd.mul_sel  = MS_DOT;
                w_cmd.mul_dest = (r_k == 2'd0) ? MD_ACC_SET : MD_ACC_ADD;
                if (r_k == 2'd2) begin
                    n_state = S_DOTW;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end
            S_DOTW: begin
                n_state = S_CLAMP;
            end
            S_CLAMP: begin
                w_cmd.clamp = 1'b1;
                n_state     = S_MSQ;
            end
            S_MSQ: begin
                w_cmd.mul_go   = 1'b1;
                w_cmd.mul_sel  = MS_MAG;
                w_cmd.mul_dest = MD_ACC_SET;
                n_state        = S_MSQW;
            end
            S_MSQW: begin
                n_state = S_YSQRT;
            end
            S_YSQRT: begin
                w_cmd.sqrt_start = 1'b1;
                w_cmd.sqrt_src   = 1'b1;
                n_state          = S_YSQRTW;
            end
            S_YSQRTW: begin
                w_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_last) begin
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                w_cmd.cord_init = 1'b1;
                n_state         = S_CORD;
            end
            S_CORD: begin
                w_cmd.cord_step = 1'b1;
                if (i_stat.cord_last) begin
                    n_state = S_AMSQ;
                end
            end
            S_AMSQ: begin
                w_cmd.mul_go   = 1'b1;
                w_cmd.mul_sel  = MS_AM;
                w_cmd.mul_dest = MD_ACC_SET;
                n_state        = S_AMW;
            end
            S_AMW: begin
                n_state = S_SUM;
            end
            S_SUM: begin
                w_cmd.sum_add = 1'b1;
                if (!r_closing) begin
                    n_state = S_COMMIT;
                end else if (!r_pair) begin
                    n_pair  = 1'b1;
                    n_k     = '0;
                    n_state = S_DOT;
                end else begin
                    n_state = S_ENLO;
                end
            end
            S_COMMIT: begin
                w_cmd.commit = 1'b1;
                n_state      = S_LAST;
            end
            S_LAST: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (i_stat.seen != 2'd3) begin
                    n_short = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_closing = 1'b1;
                    n_state   = S_DIFF;
                end
            end
            S_ENLO: begin
                w_cmd.mul_go   = 1'b1;
                w_cmd.mul_sel  = MS_ELO;
                w_cmd.mul_dest = MD_AUX_SET;
                n_short        = 1'b0;
                n_state        = S_ENHI;
            end
            S_ENHI: begin
                w_cmd.mul_go   = 1'b1;
                w_cmd.mul_sel  = MS_EHI;
                w_cmd.mul_dest = MD_ACC_SET;
                n_state        = S_ENW;
            end
            S_ENW: begin
                n_state = S_EMIT;
            end
            // hold until the output register is free
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_short     = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd       = w_cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== design/closed_chain_bending_energy_core.sv =====
// Channel   Valid        Ready        Payload
// input     i_in_valid   o_in_ready   i_coord_x, i_coord_y, i_coord_z, i_last_vertex
// output    o_out_valid  i_out_ready  o_energy, o_degenerate
// config    i_cfg_wr_en  (none)       i_cfg_wr_data (rigidity)
//
// One vertex at a time. The first vertex of a chain is stored; every later
// vertex needs normalization (up to 30 shifts), a 32-step square root and a
// 31-step divider for its unit vector, plus a second 32-step square root and
// the CORDIC loop per angle.
// The last vertex adds the closing edge and two more angles, then the energy
// product. Synchronous active-low reset clears control state
// and sets rigidity to 1.0. A waiting result does not block the next vertex;
// a new result waits in its emit state until the output register is taken.
module closed_chain_bending_energy_core import ccbe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic               i_last_vertex,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [47:0]        o_energy,
    output logic               o_degenerate,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    ccbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    // arithmetic and chain state
    ccbe_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_last_vertex (i_last_vertex),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_stat        (w_stat),
        .o_energy      (o_energy),
        .o_degenerate  (o_degenerate)
    );

endmodule

// ===== design/ccbe_checker.sv =====
module ccbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        i_last_vertex,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [47:0] o_energy,
    input logic        o_degenerate
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_energy) && $stable(o_degenerate))
        else $error("stalled result changed");

    // one vertex at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken in back-to-back cycles");

    // a vertex without the last flag never raises a result next cycle
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_last_vertex |=> !$rose(o_out_valid))
        else $error("result right after an inner vertex");

endmodule

bind closed_chain_bending_energy_core ccbe_checker u_ccbe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_last_vertex (i_last_vertex),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_energy      (o_energy),
    .o_degenerate  (o_degenerate)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import ccbe_pkg::*; ();

    typedef longint t_vec3 [3];

    typedef struct {
        logic [47:0] energy;
        logic        degenerate;
    } t_energy_result;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
        logic               known;
        logic [47:0]        energy;
        logic               degenerate;
    } t_vertex_row;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 300;
    localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMIN = 32'sh8000_0000;

    // arctan(2^-i), Q32 radians
    localparam longint ATAN_TAB [32] = '{
        64'd3373259426, 1991351318, 1052175346, 534100635,
        268086748, 134174063, 67103403, 33553749,
        16777131, 8388597, 4194303, 2097152,
        1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512,
        256, 128, 64, 32,
        16, 8, 4, 2
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic signed [31:0] i_coord_z = '0;
    logic               i_last_vertex = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [47:0]        o_energy;
    logic               o_degenerate;
    logic               i_cfg_wr_en = 1'b0;
    logic [31:0]        i_cfg_wr_data = '0;

    closed_chain_bending_energy_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_last_vertex (i_last_vertex),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_energy      (o_energy),
        .o_degenerate  (o_degenerate),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // chain state of the predictor
    logic [31:0]    pr_rigidity = RIGIDITY_RESET;
    t_vertex_row    stim_rows [$];
    t_vec3          pr_first_vtx;
    t_vec3          pr_prev_vtx;
    t_vec3          pr_first_unit;
    t_vec3          pr_prev_unit;
    logic [63:0]    pr_angle_sum = '0;
    int             pr_seen = 0;
    logic           pr_degen = 1'b0;

    t_energy_result energy_pending [$];
    int             errors = 0;
    int             vertices_sent = 0;
    int             chains_checked = 0;
    int             saturated_seen = 0;
    int             idle_cycles = 0;
    logic           no_idle = 1'b0;
    int             out_stall = 0;

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root64(input logic [63:0] val);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > val) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (val >= res + bitv) begin
                val = val - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // unit vector of an edge, Q2.30; zero edge gives zero and flags the chain
    task automatic edge_unit(input t_vec3 d, output t_vec3 u);
        logic [63:0] m [3];
        logic [63:0] mx;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] q;
        mx = '0;
        s  = '0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) begin
            u = '{0, 0, 0};
            pr_degen = 1'b1;
            return;
        end
        while (mx >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            mx = mx >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            mx = mx << 1;
        end
        for (int i = 0; i < 3; i++) s = s + m[i] * m[i];
        r = root64(s);
        for (int i = 0; i < 3; i++) begin
            q = ((m[i] << 30) + (r >> 1)) / r;
            if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
            u[i] = (d[i] < 0) ? -longint'(q) : longint'(q);
        end
    endtask

    // squared angle between two unit vectors, added to the running sum
    task automatic add_bend(input t_vec3 a, input t_vec3 b);
        longint      p;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        longint      xs;
        longint      ys;
        logic [63:0] mag;
        logic [63:0] am;
        logic [63:0] sq;
        p = 0;
        z = 0;
        for (int i = 0; i < 3; i++) p = p + a[i] * b[i];
        mag = (p < 0) ? 64'(-p) : 64'(p);
        mag = (mag + (64'd1 << 29)) >> 30;
        if (mag > 64'(ONE_Q30)) mag = 64'(ONE_Q30);
        x = (p < 0) ? -longint'(mag) : longint'(mag);
        y = longint'(root64((64'd1 << 60) - mag * mag));
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = longint'(HALF_PI_Q32);
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TAB[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TAB[i];
            end
        end
        if (z < 0) z = 0;
        if (z > longint'(PI_Q32)) z = longint'(PI_Q32);
        am = (64'(z) + 64'd8) >> 4;
        sq = (am * am + (64'd1 << 31)) >> 32;
        pr_angle_sum = (pr_angle_sum > ~64'd0 - sq) ? ~64'd0 : pr_angle_sum + sq;
    endtask

    // advance the predictor by one vertex; flag a result on the last one
    task automatic predict_vertex(input t_vertex_row row, output logic has_res,
                                  output t_energy_result res);
        t_vec3       v;
        t_vec3       d;
        t_vec3       e;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] en;
        v = '{longint'(row.x), longint'(row.y), longint'(row.z)};
        has_res = 1'b0;
        res = '{energy: '0, degenerate: 1'b0};
        if (pr_seen == 0) begin
            pr_first_vtx = v;
            pr_prev_vtx  = v;
        end else begin
            for (int i = 0; i < 3; i++) d[i] = v[i] - pr_prev_vtx[i];
            edge_unit(d, e);
            if (pr_seen == 1) pr_first_unit = e;
            else add_bend(pr_prev_unit, e);
            pr_prev_unit = e;
            pr_prev_vtx  = v;
        end
        if (pr_seen < 3) pr_seen++;
        if (!row.last) return;
        has_res = 1'b1;
        if (pr_seen < 3) begin
            res = '{energy: '0, degenerate: 1'b1};
        end else begin
            for (int i = 0; i < 3; i++) d[i] = pr_first_vtx[i] - v[i];
            edge_unit(d, e);
            add_bend(pr_prev_unit, e);
            add_bend(e, pr_first_unit);
            lo = {32'd0, pr_angle_sum[31:0]} * {32'd0, pr_rigidity};
            hi = (pr_angle_sum >> 32) * {32'd0, pr_rigidity};
            if (hi >= (64'd1 << 33)) begin
                en = 64'(ENERGY_MAX);
            end else begin
                en = (hi << 15) + (lo >> 17);
                if (en > 64'(ENERGY_MAX)) en = 64'(ENERGY_MAX);
            end
            res = '{energy: en[47:0], degenerate: pr_degen};
        end
        pr_seen      = 0;
        pr_angle_sum = '0;
        pr_degen     = 1'b0;
        pr_first_vtx = '{0, 0, 0};
        pr_prev_vtx  = '{0, 0, 0};
        pr_first_unit = '{0, 0, 0};
        pr_prev_unit = '{0, 0, 0};
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic void add_row(input logic signed [31:0] x, input logic signed [31:0] y,
                                    input logic signed [31:0] z, input logic last,
                                    input logic known, input logic [47:0] energy,
                                    input logic degenerate);
        stim_rows.push_back('{x: x, y: y, z: z, last: last, known: known,
                              energy: energy, degenerate: degenerate});
    endfunction

    // drive one vertex and hold it until the transaction completes
    task automatic send_vertex(input t_vertex_row row);
        logic           has_res;
        t_energy_result res;
        int             gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_coord_x     <= row.x;
        i_coord_y     <= row.y;
        i_coord_z     <= row.z;
        i_last_vertex <= row.last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_vertex(row, has_res, res);
        vertices_sent++;
        if (has_res) begin
            if (row.known) res = '{energy: row.energy, degenerate: row.degenerate};
            energy_pending.push_back(res);
        end
    endtask

    function automatic logic signed [31:0] rand_coord(input int style,
                                                      input logic signed [31:0] prev);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return prev;
        if (style == 1) return $urandom;
        if (style == 2) begin
            case ($urandom_range(0, 3))
                0: return CMAX;
                1: return CMIN;
                2: return 0;
                default: return $urandom;
            endcase
        end
        return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
    endfunction

    // one closed chain with random shape and content
    task automatic send_chain();
        int                 kind;
        int                 len;
        int                 style;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        t_vertex_row        row;
        kind  = $urandom_range(0, 39);
        style = $urandom_range(0, 3) == 0 ? 1 : ($urandom_range(0, 5) == 0 ? 2 : 0);
        px = 0;
        py = 0;
        pz = 0;
        if (kind == 0) begin
            // back-and-forth chain: bends between the long edges are close to pi
            len = $urandom_range(56, 64);
            for (int k = 0; k < len; k++) begin
                row = '{x: (k % 2) ? 32'sh0100_0000 : 32'sh0, y: 32'($urandom_range(0, 3)),
                        z: 0, last: k == len - 1, known: 0, energy: 0, degenerate: 0};
                send_vertex(row);
            end
            return;
        end
        len = (kind < 4) ? $urandom_range(1, 2) : $urandom_range(3, 10);
        for (int k = 0; k < len; k++) begin
            px = rand_coord(style, px);
            py = rand_coord(style, py);
            pz = rand_coord(style, pz);
            row = '{x: px, y: py, z: pz, last: k == len - 1, known: 0, energy: 0,
                    degenerate: 0};
            send_vertex(row);
        end
    endtask

    task automatic wait_drained();
        while (energy_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_rigidity(input logic [31:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        pr_rigidity = val;
    endtask

    // check each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        t_energy_result exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (energy_pending.size() == 0) begin
                $error("unexpected result energy=%0h degenerate=%0b", o_energy, o_degenerate);
                errors++;
            end else begin
                exp_res = energy_pending.pop_front();
                chains_checked++;
                if (exp_res.energy == ENERGY_MAX) saturated_seen++;
                if (o_energy !== exp_res.energy) begin
                    $error("energy expected %0h actual %0h", exp_res.energy, o_energy);
                    errors++;
                end
                if (o_degenerate !== exp_res.degenerate) begin
                    $error("degenerate expected %0b actual %0b", exp_res.degenerate,
                           o_degenerate);
                    errors++;
                end
            end
        end
        // output back-pressure: mostly ready, with short and long stalls
        if (no_idle) begin
            i_out_ready <= 1'b1;
        end else if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 4) out_stall = $urandom_range(10, 60);
            i_out_ready <= $urandom_range(0, 99) >= 30;
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[closed_chain_bending_energy_core] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] phase_rig [4];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed chains under the reset rigidity
        add_row(0, 0, 0, 1, 1, 48'd0, 1'b1);
        add_row(CMAX, CMIN, 0, 0, 0, 0, 0);
        add_row(CMIN, CMAX, -1, 1, 1, 48'd0, 1'b1);
        add_row(0, 0, 0, 0, 0, 0, 0);
        add_row(32'sh0001_0000, 0, 0, 0, 0, 0, 0);
        add_row(32'sh0002_0000, 0, 0, 1, 0, 0, 0);
        add_row(CMAX, CMAX, CMAX, 0, 0, 0, 0);
        add_row(CMIN, CMIN, CMIN, 0, 0, 0, 0);
        add_row(CMAX, CMIN, 0, 1, 0, 0, 0);
        add_row(5, 5, 5, 0, 0, 0, 0);
        add_row(5, 5, 5, 0, 0, 0, 0);
        add_row(7, -3, 9, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0);
        add_row(32'sh0001_0000, 0, 0, 0, 0, 0, 0);
        add_row(32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, 0, 0);
        add_row(0, 32'sh0001_0000, 0, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 0, 0);
        add_row(0, 1, 0, 0, 0, 0, 0);
        add_row(0, 0, 1, 1, 0, 0, 0);
        foreach (stim_rows[k]) send_vertex(stim_rows[k]);
        i_in_valid <= 1'b0;
        wait_drained();

        // random chains under several rigidity settings
        phase_rig = '{32'd0, 32'hFFFF_FFFF, $urandom, 32'd1};
        for (int ph = 0; ph < 4; ph++) begin
            write_rigidity(phase_rig[ph]);
            no_idle = (ph == 2);
            while (vertices_sent < 20 + 200 * (ph + 1)) send_chain();
            i_in_valid <= 1'b0;
            no_idle = 1'b0;
            wait_drained();
        end

        $display("covered %0d vertices, %0d chain energies checked, %0d saturated",
                 vertices_sent, chains_checked, saturated_seen);
        $display("rigidity settings: reset, zero, all ones, random, one lsb");
        if (errors == 0) begin
            $display("[closed_chain_bending_energy_core] OK");
        end else begin
            $display("[closed_chain_bending_energy_core] ERROR");
        end
        $finish;
    end

endmodule
